/* hw/rtl/dba_pkg.sv */
package dba_pkg;

  // Sizing
  localparam int MAX_STRANDS = 32;
  localparam int MIN_STRANDS = 3;
  localparam int COORD_BITS  = 32;
  localparam int NPAIRS      = MAX_STRANDS - 2;

  // Field widths fixed by the ports
  localparam int STRANDS_W = 6;
  localparam int CMD_W     = 2;
  localparam int GEN_W     = 5;
  localparam int PAIR_W    = 5;
  localparam int DATA_W    = 32;

  // Derived widths
  localparam int NS_W       = (STRANDS_W > $clog2(MAX_STRANDS + 1)) ?
                              STRANDS_W : $clog2(MAX_STRANDS + 1);
  localparam int PIDX_W     = $clog2(NPAIRS);
  localparam int BANK_DEPTH = NPAIRS / 2 + 1;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam int EXT_W      = ((COORD_BITS > DATA_W) ? COORD_BITS : DATA_W) + 4;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_W-1:0]      ext_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
  } cpair_t;

  typedef struct packed {
    logic   ovf;
    coord_t val;
  } clamp_t;

  typedef struct packed {
    logic [PAIR_W-1:0]        pair;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     last;
    logic                     status;
    logic                     ovf;
  } res_t;

  // Positive part
  function automatic ext_t pos_part(ext_t x);
    return (x > 0) ? x : '0;
  endfunction

  // Negative part
  function automatic ext_t neg_part(ext_t x);
    return (x < 0) ? x : '0;
  endfunction

  // Saturate to the coordinate range, flag when clipped
  function automatic clamp_t clamp_coord(ext_t v);
    clamp_t r;
    ext_t   cmax;
    ext_t   cmin;
    cmax = ext_t'({1'b0, {(COORD_BITS - 1){1'b1}}});
    cmin = ~cmax;
    if (v > cmax) begin
      r.ovf = 1'b1;
      r.val = coord_t'(cmax);
    end else if (v < cmin) begin
      r.ovf = 1'b1;
      r.val = coord_t'(cmin);
    end else begin
      r.ovf = 1'b0;
      r.val = coord_t'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/dynnikov_braid_action.sv */
// An accepted item is registered in stage one, then its result in the result
// register on the out_ port. One item per cycle unless out_stall holds it back;
// an interior generator gives two results and holds the one result port for both.
// Coordinates live in two banks (even and odd pairs), so both pairs of a generator
// are read together; a bypass covers the write made at the same edge.
// Reset (sync, active low): all pairs read as zero, overflow clear, strands = 3.
module dynnikov_braid_action (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dba_pkg::STRANDS_W-1:0]         cfg_strands,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dba_pkg::CMD_W-1:0]             in_command,
  input  logic [dba_pkg::GEN_W-1:0]             in_generator_index,
  input  logic                                  in_generator_positive,
  input  logic [dba_pkg::PAIR_W-1:0]            in_pair_index,
  input  logic signed [dba_pkg::DATA_W-1:0]     in_a_in,
  input  logic signed [dba_pkg::DATA_W-1:0]     in_b_in,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dba_pkg::PAIR_W-1:0]            out_pair_out,
  output logic signed [dba_pkg::DATA_W-1:0]     out_a_out,
  output logic signed [dba_pkg::DATA_W-1:0]     out_b_out,
  output logic                                  out_last,
  output logic                                  out_status,
  output logic                                  out_overflow
);

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EDGE1 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDGEN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MID   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERR   = 3'd5;

  // Configuration
  logic [dba_pkg::STRANDS_W-1:0] strands_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strands_r <= dba_pkg::STRANDS_W'(dba_pkg::MIN_STRANDS);
    end else if (cfg_valid && cfg_ready) begin
      strands_r <= cfg_strands;
    end
  end

  // Decode the incoming item
  logic [dba_pkg::NS_W-1:0]   n_raw, n_cl, k_w, g_w, lp_w;
  logic                       pair_ok, gen_ok;
  logic [KIND_W-1:0]          kind_d;
  logic [dba_pkg::PIDX_W-1:0] lp_d;
  logic [dba_pkg::ROW_W-1:0]  row0_d, row1_d;
  logic                       in_accept;

  always_comb begin
    n_raw = dba_pkg::NS_W'(strands_r);
    if (n_raw < dba_pkg::NS_W'(dba_pkg::MIN_STRANDS)) begin
      n_cl = dba_pkg::NS_W'(dba_pkg::MIN_STRANDS);
    end else if (n_raw > dba_pkg::NS_W'(dba_pkg::MAX_STRANDS)) begin
      n_cl = dba_pkg::NS_W'(dba_pkg::MAX_STRANDS);
    end else begin
      n_cl = n_raw;
    end
    k_w     = dba_pkg::NS_W'(in_pair_index);
    g_w     = dba_pkg::NS_W'(in_generator_index);
    pair_ok = (k_w >= dba_pkg::NS_W'(1)) && (k_w <= n_cl - dba_pkg::NS_W'(2));
    gen_ok  = (g_w >= dba_pkg::NS_W'(1)) && (g_w <= n_cl - dba_pkg::NS_W'(1));
    kind_d  = KIND_ERR;
    lp_w    = '0;
    case (in_command)
      dba_pkg::CMD_WRITE, dba_pkg::CMD_READ: begin
        if (pair_ok) begin
          kind_d = (in_command == dba_pkg::CMD_WRITE) ? KIND_WRITE : KIND_READ;
          lp_w   = k_w - dba_pkg::NS_W'(1);
        end
      end
      dba_pkg::CMD_APPLY: begin
        if (!gen_ok) begin
          kind_d = KIND_ERR;
        end else if (g_w == dba_pkg::NS_W'(1)) begin
          kind_d = KIND_EDGE1;
          lp_w   = '0;
        end else if (g_w == n_cl - dba_pkg::NS_W'(1)) begin
          kind_d = KIND_EDGEN;
          lp_w   = n_cl - dba_pkg::NS_W'(3);
        end else begin
          kind_d = KIND_MID;
          lp_w   = g_w - dba_pkg::NS_W'(2);
        end
      end
      default: begin
        kind_d = KIND_ERR;
      end
    endcase
    lp_d   = dba_pkg::PIDX_W'(lp_w);
    // Pair lp sits in bank lp[0]; its neighbor lp+1 sits in the other bank
    row1_d = dba_pkg::ROW_W'(lp_d >> 1);
    row0_d = lp_d[0] ? row1_d + dba_pkg::ROW_W'(1) : row1_d;
  end

  // Stage one: item register and bank read data
  logic                             s1_v_r;
  logic [KIND_W-1:0]                s1_kind_r;
  logic [dba_pkg::PIDX_W-1:0]       s1_lp_r;
  logic                             s1_pos_r;
  logic signed [dba_pkg::DATA_W-1:0] s1_a_r, s1_b_r;
  logic [dba_pkg::ROW_W-1:0]        s1_row0_r, s1_row1_r;
  dba_pkg::cpair_t                  rd0_r, rd1_r;
  logic                             rdv0_r, rdv1_r;
  logic                             s1_adv;

  dba_pkg::cpair_t mem0 [dba_pkg::BANK_DEPTH];
  dba_pkg::cpair_t mem1 [dba_pkg::BANK_DEPTH];
  logic [dba_pkg::BANK_DEPTH-1:0] vld0_r, vld1_r;

  // Bank write side and last-write bypass
  logic                      we0, we1;
  dba_pkg::cpair_t           wd0, wd1;
  logic                      fwd0_v_r, fwd1_v_r;
  logic [dba_pkg::ROW_W-1:0] fwd0_row_r, fwd1_row_r;
  dba_pkg::cpair_t           fwd0_dat_r, fwd1_dat_r;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Capture the item and read both banks
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= kind_d;
      s1_lp_r   <= lp_d;
      s1_pos_r  <= in_generator_positive;
      s1_a_r    <= in_a_in;
      s1_b_r    <= in_b_in;
      s1_row0_r <= row0_d;
      s1_row1_r <= row1_d;
      rd0_r     <= mem0[row0_d];
      rd1_r     <= mem1[row1_d];
      rdv0_r    <= vld0_r[row0_d];
      rdv1_r    <= vld1_r[row1_d];
    end
  end

  // Write the banks on commit
  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[s1_row0_r] <= wd0;
    end
    if (we1) begin
      mem1[s1_row1_r] <= wd1;
    end
  end

  // Mark written entries and remember the latest write per bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r   <= '0;
      vld1_r   <= '0;
      fwd0_v_r <= 1'b0;
      fwd1_v_r <= 1'b0;
    end else begin
      if (we0) begin
        vld0_r[s1_row0_r] <= 1'b1;
        fwd0_v_r          <= 1'b1;
      end
      if (we1) begin
        vld1_r[s1_row1_r] <= 1'b1;
        fwd1_v_r          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      fwd0_row_r <= s1_row0_r;
      fwd0_dat_r <= wd0;
    end
    if (we1) begin
      fwd1_row_r <= s1_row1_r;
      fwd1_dat_r <= wd1;
    end
  end

  // Operands: bypass, else stored value, else reset value
  dba_pkg::cpair_t bank0_q, bank1_q, lo_q, hi_q;

  always_comb begin
    if (fwd0_v_r && fwd0_row_r == s1_row0_r) begin
      bank0_q = fwd0_dat_r;
    end else begin
      bank0_q = rdv0_r ? rd0_r : '0;
    end
    if (fwd1_v_r && fwd1_row_r == s1_row1_r) begin
      bank1_q = fwd1_dat_r;
    end else begin
      bank1_q = rdv1_r ? rd1_r : '0;
    end
    lo_q = s1_lp_r[0] ? bank1_q : bank0_q;
    hi_q = s1_lp_r[0] ? bank0_q : bank1_q;
  end

  // Update rules
  dba_pkg::ext_t  xa, xb, xa2, xb2, t, na1, nb1, na2, nb2;
  dba_pkg::clamp_t ca1, cb1, ca2, cb2;
  logic           lo_we, hi_we, item_ovf;

  always_comb begin
    xa  = dba_pkg::ext_t'(lo_q.a);
    xb  = dba_pkg::ext_t'(lo_q.b);
    xa2 = dba_pkg::ext_t'(hi_q.a);
    xb2 = dba_pkg::ext_t'(hi_q.b);
    t   = '0;
    na1 = xa;
    nb1 = xb;
    na2 = xa2;
    nb2 = xb2;
    case (s1_kind_r)
      KIND_WRITE: begin
        na1 = dba_pkg::ext_t'(s1_a_r);
        nb1 = dba_pkg::ext_t'(s1_b_r);
      end
      KIND_EDGE1: begin
        if (s1_pos_r) begin
          nb1 = xa + dba_pkg::pos_part(xb);
          na1 = -xb + dba_pkg::pos_part(nb1);
        end else begin
          nb1 = -xa + dba_pkg::pos_part(xb);
          na1 = xb - dba_pkg::pos_part(nb1);
        end
      end
      KIND_EDGEN: begin
        if (s1_pos_r) begin
          nb1 = xa + dba_pkg::neg_part(xb);
          na1 = -xb + dba_pkg::neg_part(nb1);
        end else begin
          nb1 = -xa + dba_pkg::neg_part(xb);
          na1 = xb - dba_pkg::neg_part(nb1);
        end
      end
      KIND_MID: begin
        if (s1_pos_r) begin
          t   = xa - xa2 - dba_pkg::pos_part(xb2) + dba_pkg::neg_part(xb);
          na1 = xa - dba_pkg::pos_part(xb) - dba_pkg::pos_part(dba_pkg::pos_part(xb2) + t);
          nb1 = xb2 + dba_pkg::neg_part(t);
          na2 = xa2 - dba_pkg::neg_part(xb2) - dba_pkg::neg_part(dba_pkg::neg_part(xb) - t);
          nb2 = xb - dba_pkg::neg_part(t);
        end else begin
          t   = xa - xa2 + dba_pkg::pos_part(xb2) - dba_pkg::neg_part(xb);
          na1 = xa + dba_pkg::pos_part(xb) + dba_pkg::pos_part(dba_pkg::pos_part(xb2) - t);
          nb1 = xb2 - dba_pkg::pos_part(t);
          na2 = xa2 + dba_pkg::neg_part(xb2) + dba_pkg::neg_part(dba_pkg::neg_part(xb) + t);
          nb2 = xb + dba_pkg::pos_part(t);
        end
      end
      default: begin
        na1 = xa;
        nb1 = xb;
      end
    endcase
    ca1 = dba_pkg::clamp_coord(na1);
    cb1 = dba_pkg::clamp_coord(nb1);
    ca2 = dba_pkg::clamp_coord(na2);
    cb2 = dba_pkg::clamp_coord(nb2);

    lo_we = (s1_kind_r == KIND_WRITE) || (s1_kind_r == KIND_EDGE1) ||
            (s1_kind_r == KIND_EDGEN) || (s1_kind_r == KIND_MID);
    hi_we = (s1_kind_r == KIND_MID);
    item_ovf = (lo_we && (ca1.ovf || cb1.ovf)) || (hi_we && (ca2.ovf || cb2.ovf));

    // Route the lower pair to its bank, the upper pair to the other
    we0 = s1_adv && (s1_lp_r[0] ? hi_we : lo_we);
    we1 = s1_adv && (s1_lp_r[0] ? lo_we : hi_we);
    wd0 = s1_lp_r[0] ? dba_pkg::cpair_t'{a: ca2.val, b: cb2.val}
                     : dba_pkg::cpair_t'{a: ca1.val, b: cb1.val};
    wd1 = s1_lp_r[0] ? dba_pkg::cpair_t'{a: ca1.val, b: cb1.val}
                     : dba_pkg::cpair_t'{a: ca2.val, b: cb2.val};
  end

  // Sticky overflow
  logic overflow_r, overflow_nxt;

  assign overflow_nxt = overflow_r || (s1_adv && item_ovf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overflow_r <= 1'b0;
    end else begin
      overflow_r <= overflow_nxt;
    end
  end

  // Build result items
  dba_pkg::res_t res0, res1;

  always_comb begin
    res1.pair   = dba_pkg::PAIR_W'(s1_lp_r) + dba_pkg::PAIR_W'(2);
    res1.a      = dba_pkg::DATA_W'(ca2.val);
    res1.b      = dba_pkg::DATA_W'(cb2.val);
    res1.last   = 1'b1;
    res1.status = dba_pkg::STATUS_OK;
    res1.ovf    = overflow_nxt;
    if (s1_kind_r == KIND_ERR) begin
      res0.pair   = '0;
      res0.a      = '0;
      res0.b      = '0;
      res0.last   = 1'b1;
      res0.status = dba_pkg::STATUS_BAD_INDEX;
    end else begin
      res0.pair   = dba_pkg::PAIR_W'(s1_lp_r) + dba_pkg::PAIR_W'(1);
      res0.a      = dba_pkg::DATA_W'(ca1.val);
      res0.b      = dba_pkg::DATA_W'(cb1.val);
      res0.last   = (s1_kind_r != KIND_MID);
      res0.status = dba_pkg::STATUS_OK;
    end
    res0.ovf = overflow_nxt;
  end

  // Result register with a second slot for interior generators
  logic          o_v_r, o1_v_r;
  dba_pkg::res_t o0_r, o1_r;
  logic          out_take, out_free;

  assign out_take = o_v_r && !out_stall;
  assign out_free = !o_v_r || (out_take && !o1_v_r);
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      o1_v_r <= 1'b0;
    end else if (s1_adv) begin
      o_v_r  <= 1'b1;
      o1_v_r <= (s1_kind_r == KIND_MID);
    end else if (out_take) begin
      o_v_r  <= o1_v_r;
      o1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o0_r <= res0;
      o1_r <= res1;
    end else if (out_take && o1_v_r) begin
      o0_r <= o1_r;
    end
  end

  assign out_valid    = o_v_r;
  assign out_pair_out = o0_r.pair;
  assign out_a_out    = o0_r.a;
  assign out_b_out    = o0_r.b;
  assign out_last     = o0_r.last;
  assign out_status   = o0_r.status;
  assign out_overflow = o0_r.ovf;

  // Checks
  a_slot1_needs_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    o1_v_r |-> o_v_r)
    else $error("second result slot full while first is empty");

  a_mid_gives_two: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_kind_r == KIND_MID) |=> (o_v_r && o1_v_r && !out_last))
    else $error("interior generator did not queue two results");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == dba_pkg::STATUS_BAD_INDEX) |->
      (out_pair_out == '0 && out_last))
    else $error("error result malformed");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (out_valid && out_last))
    else $error("first of two results not followed by the last one");

endmodule

/* tb/tb.sv */
module tb;
  import dba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int INT_HI           = 32'sh7fff_ffff;
  localparam int INT_LO           = 32'sh8000_0000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 300;
  localparam int HOLD_SPACING     = 350;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PRINT_CAP        = 40;

  typedef struct {
    logic [CMD_W-1:0]         command;
    logic [GEN_W-1:0]         generator_index;
    logic                     generator_positive;
    logic [PAIR_W-1:0]        pair_index;
    logic signed [DATA_W-1:0] a_val;
    logic signed [DATA_W-1:0] b_val;
  } braid_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [STRANDS_W-1:0]         cfg_strands = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [CMD_W-1:0]             in_command = '0;
  logic [GEN_W-1:0]             in_generator_index = '0;
  logic                         in_generator_positive = 1'b0;
  logic [PAIR_W-1:0]            in_pair_index = '0;
  logic signed [DATA_W-1:0]     in_a_in = '0;
  logic signed [DATA_W-1:0]     in_b_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [PAIR_W-1:0]            out_pair_out;
  logic signed [DATA_W-1:0]     out_a_out;
  logic signed [DATA_W-1:0]     out_b_out;
  logic                         out_last;
  logic                         out_status;
  logic                         out_overflow;

  // Shadow of the block state
  logic [STRANDS_W-1:0] strands_reg = 6'd3;
  coord_t               coord_a [NPAIRS] = '{default: '0};
  coord_t               coord_b [NPAIRS] = '{default: '0};
  logic                 ovf_seen = 1'b0;

  braid_item_t pending_items [$];
  res_t        expected_results [$];
  braid_item_t offered;
  res_t        want;

  int errors       = 0;
  int items_taken  = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int hold_left    = 0;
  int next_hold_at = 150;
  int stall_mode   = 0;
  int mode_left    = 0;
  int cycles       = 0;
  logic stall_now;

  dynnikov_braid_action i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_strands           (cfg_strands),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_generator_index    (in_generator_index),
    .in_generator_positive (in_generator_positive),
    .in_pair_index         (in_pair_index),
    .in_a_in               (in_a_in),
    .in_b_in               (in_b_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pair_out          (out_pair_out),
    .out_a_out             (out_a_out),
    .out_b_out             (out_b_out),
    .out_last              (out_last),
    .out_status            (out_status),
    .out_overflow          (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint pos_of(longint x);
    return (x > 0) ? x : 0;
  endfunction

  function automatic longint neg_of(longint x);
    return (x < 0) ? x : 0;
  endfunction

  // Saturate to the coordinate range and raise the sticky flag on a clip
  function automatic coord_t clip_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf_seen = 1'b1;
      return coord_t'(hi);
    end else if (v < lo) begin
      ovf_seen = 1'b1;
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  function automatic int strands_clamped();
    int n;
    n = strands_reg;
    if (n < MIN_STRANDS) n = MIN_STRANDS;
    else if (n > MAX_STRANDS) n = MAX_STRANDS;
    return n;
  endfunction

  // Append an item to the tail of the pending queue
  function automatic void queue_item(braid_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_pair_result(int pair, logic last, logic status);
    res_t r;
    r.pair   = PAIR_W'(pair);
    r.a      = (status == STATUS_OK) ? coord_a[pair-1] : '0;
    r.b      = (status == STATUS_OK) ? coord_b[pair-1] : '0;
    r.last   = last;
    r.status = status;
    r.ovf    = ovf_seen;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one item to the shadow state and queue the pairs it reports.
  // Intermediates of 32-bit coordinates stay well inside 64 bits.
  function automatic void predict_braid_step(braid_item_t it);
    int     n, k, gi, p;
    logic   pos;
    longint ca, cb, na, nb, a1, b1, a2, b2, t, na1, nb1, na2, nb2;
    n   = strands_clamped();
    k   = it.pair_index;
    gi  = it.generator_index;
    pos = it.generator_positive;
    if (it.command == CMD_WRITE || it.command == CMD_READ) begin
      if (k < 1 || k > n - 2) begin
        push_pair_result(0, 1'b1, STATUS_BAD_INDEX);
      end else begin
        if (it.command == CMD_WRITE) begin
          coord_a[k-1] = clip_coord(longint'(it.a_val));
          coord_b[k-1] = clip_coord(longint'(it.b_val));
        end
        push_pair_result(k, 1'b1, STATUS_OK);
      end
    end else if (it.command != CMD_APPLY || gi < 1 || gi > n - 1) begin
      push_pair_result(0, 1'b1, STATUS_BAD_INDEX);
    end else if (gi == 1 || gi == n - 1) begin
      // edge rules: first generator first, last generator otherwise
      p  = (gi == 1) ? 0 : n - 3;
      ca = coord_a[p];
      cb = coord_b[p];
      if (gi == 1) begin
        if (pos) begin
          nb = ca + pos_of(cb);
          na = -cb + pos_of(nb);
        end else begin
          nb = -ca + pos_of(cb);
          na = cb - pos_of(nb);
        end
      end else begin
        if (pos) begin
          nb = ca + neg_of(cb);
          na = -cb + neg_of(nb);
        end else begin
          nb = -ca + neg_of(cb);
          na = cb - neg_of(nb);
        end
      end
      coord_a[p] = clip_coord(na);
      coord_b[p] = clip_coord(nb);
      push_pair_result(p + 1, 1'b1, STATUS_OK);
    end else begin
      // interior rule over pairs i-1 and i
      p  = gi - 2;
      a1 = coord_a[p];
      b1 = coord_b[p];
      a2 = coord_a[p+1];
      b2 = coord_b[p+1];
      if (pos) begin
        t   = a1 - a2 - pos_of(b2) + neg_of(b1);
        na1 = a1 - pos_of(b1) - pos_of(pos_of(b2) + t);
        nb1 = b2 + neg_of(t);
        na2 = a2 - neg_of(b2) - neg_of(neg_of(b1) - t);
        nb2 = b1 - neg_of(t);
      end else begin
        t   = a1 - a2 + pos_of(b2) - neg_of(b1);
        na1 = a1 + pos_of(b1) + pos_of(pos_of(b2) - t);
        nb1 = b2 - pos_of(t);
        na2 = a2 + neg_of(b2) + neg_of(neg_of(b1) + t);
        nb2 = b1 + pos_of(t);
      end
      coord_a[p]   = clip_coord(na1);
      coord_b[p]   = clip_coord(nb1);
      coord_a[p+1] = clip_coord(na2);
      coord_b[p+1] = clip_coord(nb2);
      push_pair_result(p + 1, 1'b0, STATUS_OK);
      push_pair_result(p + 2, 1'b1, STATUS_OK);
    end
  endfunction

  function automatic braid_item_t mk_item(logic [CMD_W-1:0] cmd, int gen, logic pos,
                                          int pair, int a, int b);
    braid_item_t it;
    it.command            = cmd;
    it.generator_index    = GEN_W'(gen);
    it.generator_positive = pos;
    it.pair_index         = PAIR_W'(pair);
    it.a_val              = a;
    it.b_val              = b;
    return it;
  endfunction

  // Mostly small values so the action is visible, with some wide ones
  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return int'($urandom_range(0, 40)) - 20;
    else if (r == 7) return int'($urandom);
    else if (r == 8) return ($urandom_range(0, 1) != 0) ? INT_HI : INT_LO;
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  // Mostly well-formed commands with random content, some bad indexes
  function automatic braid_item_t rand_item(int n);
    braid_item_t it;
    int r;
    it = mk_item(CMD_APPLY, int'($urandom), 1'($urandom_range(0, 1)), int'($urandom),
                 rand_coord(), rand_coord());
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (r < 10) it.generator_index = GEN_W'(1);
      else if (r < 18) it.generator_index = GEN_W'(n - 1);
      else it.generator_index = GEN_W'($urandom_range(1, n - 1));
    end else if (r < 70) begin
      it.command    = CMD_WRITE;
      it.pair_index = PAIR_W'($urandom_range(1, n - 2));
    end else if (r < 85) begin
      it.command    = CMD_READ;
      it.pair_index = PAIR_W'($urandom_range(1, n - 2));
    end else if (r < 90) begin
      if (n < 32 && $urandom_range(0, 1) != 0) it.generator_index = GEN_W'($urandom_range(n, 31));
      else it.generator_index = '0;
    end else if (r < 95) begin
      it.command = ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ;
      if ($urandom_range(0, 1) != 0) it.pair_index = PAIR_W'($urandom_range(n - 1, 31));
      else it.pair_index = '0;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic report(string what, longint got, longint wanted);
    // keep the log short when many results go wrong
    if (errors < PRINT_CAP)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, wanted);
    errors++;
  endtask

  // Wait until all items are taken and all results are back, then let the pipe empty
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_strands(logic [STRANDS_W-1:0] v);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    cfg_strands <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    strands_reg = v;
    @(negedge clk);
  endtask

  // Drive items in bursts with random gaps; hold the payload while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_braid_step(offered);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          if (gap_left != 0) gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          offered = pending_items.pop_front();
          in_command            <= offered.command;
          in_generator_index    <= offered.generator_index;
          in_generator_positive <= offered.generator_positive;
          in_pair_index         <= offered.pair_index;
          in_a_in               <= offered.a_val;
          in_b_in               <= offered.b_val;
          in_valid              <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Hold off the receiver for a long stretch now and then so the block backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (items_taken >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  // Check each result against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, pair", out_pair_out, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_pair_out !== want.pair) report("pair_out", out_pair_out, want.pair);
          if (out_a_out !== want.a) report("a_out", out_a_out, want.a);
          if (out_b_out !== want.b) report("b_out", out_b_out, want.b);
          if (out_last !== want.last) report("last", out_last, want.last);
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_overflow !== want.ovf) report("overflow", out_overflow, want.ovf);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: stall_now = 1'b0;
        1: stall_now = ($urandom_range(0, 3) == 0);
        2: stall_now = ($urandom_range(0, 3) != 0);
        default: stall_now = (mode_left % 3 == 0);
      endcase
      out_stall <= (hold_left != 0) || stall_now;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [STRANDS_W-1:0] plan [6];
    plan = '{6'd32, 6'd0, 6'd4, 6'd63, STRANDS_W'($urandom_range(3, 32)),
             STRANDS_W'($urandom_range(0, 63))};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // three strands out of reset: both edge rules fall on the single pair
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 1, 5, -3));
    queue_item(mk_item(CMD_READ, 0, 1'b0, 1, 0, 0));
    queue_item(mk_item(CMD_APPLY, 1, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 1, 1'b0, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 2, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 2, 1'b0, 0, 0, 0));
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 0, 9, 9));
    queue_item(mk_item(CMD_READ, 0, 1'b0, 2, 0, 0));
    queue_item(mk_item(CMD_APPLY, 0, 1'b1, 1, 0, 0));
    queue_item(mk_item(CMD_APPLY, 3, 1'b0, 1, 0, 0));
    queue_item(mk_item(CMD_UNUSED, 31, 1'b1, 31, -1, -1));
    settle();

    // five strands: interior generators, then saturation from extreme values
    write_strands(6'd5);
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 1, 2, -1));
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 2, -4, 3));
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 3, 1, 1));
    queue_item(mk_item(CMD_APPLY, 2, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 3, 1'b0, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 3, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 2, 1'b0, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 4, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 4, 1'b0, 0, 0, 0));
    queue_item(mk_item(CMD_APPLY, 1, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_WRITE, 0, 1'b0, 2, INT_HI, INT_LO));
    queue_item(mk_item(CMD_APPLY, 2, 1'b1, 0, 0, 0));
    queue_item(mk_item(CMD_READ, 0, 1'b0, 3, 0, 0));
    settle();

    // random phases over several strand counts, out-of-range ones included
    foreach (plan[i]) begin
      write_strands(plan[i]);
      repeat (RANDOM_PER_PHASE) queue_item(rand_item(strands_clamped()));
      settle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* dynnikov_braid_action.f */
hw/rtl/dba_pkg.sv
hw/rtl/dynnikov_braid_action.sv
tb/tb.sv
